// ===== rtl/core/slot_admission_gate_core_assert.svh =====
// assertion macros used by the checker file
`ifndef SLOT_ADMISSION_GATE_CORE_ASSERT_SVH
`define SLOT_ADMISSION_GATE_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SAG_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("slot admission gate check failed");

// next-cycle implication, disabled during reset
`define SAG_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("slot admission gate check failed");

`endif

// ===== rtl/core/sag_pkg.sv =====
package sag_pkg;

  // sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int MIN_LIMIT   = 1;
  localparam int MAX_LIMIT   = 64;
  localparam int ID_BITS     = 8;

  localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int PTR_SUM_W = PTR_W + 1;
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_W    = $clog2(MAX_LIMIT + 1);
  localparam int SLOT_INC_W = SLOT_W + 1;
  localparam int ID_W      = ID_BITS;

  // fixed field widths
  localparam int KIND_W      = 3;
  localparam int REQ_W       = 8;
  localparam int NEW_LIMIT_W = 8;
  localparam int EVENT_W     = 4;
  localparam int WHO_W       = 8;
  localparam int ACT_OUT_W   = 7;
  localparam int Q_OUT_W     = 5;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_ACQUIRE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CANCEL  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SETLIM  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FLUSH   = 3'd4;

  // event codes
  localparam logic [EVENT_W-1:0] EV_GRANTED    = 4'd0;
  localparam logic [EVENT_W-1:0] EV_REFUSED    = 4'd1;
  localparam logic [EVENT_W-1:0] EV_QUEUED     = 4'd2;
  localparam logic [EVENT_W-1:0] EV_PROMOTED   = 4'd3;
  localparam logic [EVENT_W-1:0] EV_CANCELLED  = 4'd4;
  localparam logic [EVENT_W-1:0] EV_NOT_FOUND  = 4'd5;
  localparam logic [EVENT_W-1:0] EV_RELEASED   = 4'd6;
  localparam logic [EVENT_W-1:0] EV_LIMIT_SET  = 4'd7;
  localparam logic [EVENT_W-1:0] EV_FLUSHED    = 4'd8;
  localparam logic [EVENT_W-1:0] EV_FLUSH_DONE = 4'd9;

  // input item
  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [REQ_W-1:0]       requester;
    logic                   may_wait;
    logic [NEW_LIMIT_W-1:0] new_limit;
  } op_t;

  // result item
  typedef struct packed {
    logic [EVENT_W-1:0]   event_res;
    logic [WHO_W-1:0]     who;
    logic [ACT_OUT_W-1:0] active_count;
    logic [Q_OUT_W-1:0]   queued_count;
    logic                 last;
  } ev_t;

  // datapath micro-operations
  typedef enum logic [3:0] {
    UOP_NONE,
    UOP_LATCH,
    UOP_ACQUIRE,
    UOP_RELEASE,
    UOP_SETLIM,
    UOP_PROMOTE,
    UOP_FLUSH_ONE,
    UOP_FLUSH_DONE,
    UOP_SCAN_START,
    UOP_SCAN_STEP,
    UOP_SHIFT_WR,
    UOP_CANCEL_END
  } uop_t;

  // queue read address select
  typedef enum logic [1:0] {
    RD_HEAD,
    RD_SCAN,
    RD_SCAN_NEXT
  } rd_sel_t;

  typedef struct packed {
    uop_t    uop;
    rd_sel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    logic is_acquire;
    logic is_release;
    logic is_cancel;
    logic is_setlim;
    logic is_flush;
    logic queue_empty;
    logic rel_last;
    logic set_last;
    logic promo_last;
    logic flush_last;
    logic match;
    logic scan_end;
    logic shift_end;
    logic out_free;
  } stat_t;

  // circular pointer add, both operands below the depth
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] a,
                                               input logic [PTR_W-1:0] b);
    logic [PTR_SUM_W-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= PTR_SUM_W'(QUEUE_DEPTH)) begin
      s = s - PTR_SUM_W'(QUEUE_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

// ===== rtl/core/sag_ctrl.sv =====
module sag_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_ready,
  input  sag_pkg::stat_t stat,
  output sag_pkg::cmd_t  cmd
);
  import sag_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE       = 12'b0000_0000_0001,
    ST_DISPATCH   = 12'b0000_0000_0010,
    ST_PROMO_RD   = 12'b0000_0000_0100,
    ST_PROMO_EMIT = 12'b0000_0000_1000,
    ST_FLUSH_RD   = 12'b0000_0001_0000,
    ST_FLUSH_EMIT = 12'b0000_0010_0000,
    ST_FLUSH_DONE = 12'b0000_0100_0000,
    ST_SCAN_RD    = 12'b0000_1000_0000,
    ST_SCAN_CMP   = 12'b0001_0000_0000,
    ST_SHIFT_RD   = 12'b0010_0000_0000,
    ST_SHIFT_WR   = 12'b0100_0000_0000,
    ST_CANCEL_END = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign op_ready = (state == ST_IDLE);

  // sequencing of micro-operations
  always_comb begin
    state_next = state;
    cmd.uop    = UOP_NONE;
    cmd.rd_sel = RD_HEAD;
    unique case (state)
      ST_IDLE: begin
        if (op_valid) begin
          cmd.uop    = UOP_LATCH;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        priority if (stat.is_acquire) begin
          if (stat.out_free) begin
            cmd.uop    = UOP_ACQUIRE;
            state_next = ST_IDLE;
          end
        end else if (stat.is_release) begin
          if (stat.out_free) begin
            cmd.uop    = UOP_RELEASE;
            state_next = stat.rel_last ? ST_IDLE : ST_PROMO_RD;
          end
        end else if (stat.is_setlim) begin
          if (stat.out_free) begin
            cmd.uop    = UOP_SETLIM;
            state_next = stat.set_last ? ST_IDLE : ST_PROMO_RD;
          end
        end else if (stat.is_flush) begin
          if (!stat.queue_empty) begin
            state_next = ST_FLUSH_RD;
          end else if (stat.out_free) begin
            cmd.uop    = UOP_FLUSH_DONE;
            state_next = ST_IDLE;
          end
        end else if (stat.is_cancel) begin
          if (!stat.queue_empty) begin
            cmd.uop    = UOP_SCAN_START;
            state_next = ST_SCAN_RD;
          end else if (stat.out_free) begin
            cmd.uop    = UOP_CANCEL_END;
            state_next = ST_IDLE;
          end
        end else begin
          // undefined kind gives no result
          state_next = ST_IDLE;
        end
      end
      ST_PROMO_RD: begin
        state_next = ST_PROMO_EMIT;
      end
      ST_PROMO_EMIT: begin
        if (stat.out_free) begin
          cmd.uop    = UOP_PROMOTE;
          state_next = stat.promo_last ? ST_IDLE : ST_PROMO_RD;
        end
      end
      ST_FLUSH_RD: begin
        state_next = ST_FLUSH_EMIT;
      end
      ST_FLUSH_EMIT: begin
        if (stat.out_free) begin
          cmd.uop    = UOP_FLUSH_ONE;
          state_next = stat.flush_last ? ST_FLUSH_DONE : ST_FLUSH_RD;
        end
      end
      ST_FLUSH_DONE: begin
        if (stat.out_free) begin
          cmd.uop    = UOP_FLUSH_DONE;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        cmd.rd_sel = RD_SCAN;
        state_next = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        cmd.uop = UOP_SCAN_STEP;
        if (stat.scan_end) begin
          state_next = ST_CANCEL_END;
        end else if (stat.match) begin
          state_next = ST_SHIFT_RD;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_SHIFT_RD: begin
        cmd.rd_sel = RD_SCAN_NEXT;
        state_next = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        cmd.uop    = UOP_SHIFT_WR;
        state_next = stat.shift_end ? ST_CANCEL_END : ST_SHIFT_RD;
      end
      ST_CANCEL_END: begin
        if (stat.out_free) begin
          cmd.uop    = UOP_CANCEL_END;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/sag_datapath.sv =====
module sag_datapath (
  input  logic           clk,
  input  logic           rst,
  input  sag_pkg::op_t   op,
  input  sag_pkg::cmd_t  cmd,
  output sag_pkg::stat_t stat,
  output logic           ev_valid,
  input  logic           ev_ready,
  output sag_pkg::ev_t   ev
);
  import sag_pkg::*;

  // control state
  logic [SLOT_W-1:0] slot_limit;
  logic [SLOT_W-1:0] active_slots;
  logic [CNT_W-1:0]  wait_count;
  logic [PTR_W-1:0]  head;
  logic [CNT_W-1:0]  idx;
  logic              found;

  logic [SLOT_W-1:0] slot_limit_next;
  logic [SLOT_W-1:0] active_slots_next;
  logic [CNT_W-1:0]  wait_count_next;
  logic [PTR_W-1:0]  head_next;
  logic [CNT_W-1:0]  idx_next;
  logic              found_next;

  // payload state
  op_t             cur;
  op_t             cur_next;
  logic [ID_W-1:0] wait_queue [QUEUE_DEPTH];
  logic [ID_W-1:0] rd_data;
  ev_t             ev_next;

  // queue port signals
  logic             mem_we;
  logic [PTR_W-1:0] wr_addr;
  logic [ID_W-1:0]  wr_data;
  logic [PTR_W-1:0] rd_addr;

  // derived values
  logic [SLOT_W-1:0]     lim_clamped;
  logic [SLOT_W-1:0]     act_dec;
  logic [SLOT_INC_W-1:0] act_inc;
  logic [CNT_W-1:0]      idx_inc;
  logic [CNT_W-1:0]      idx_inc2;
  logic                  can_grant;
  logic                  queue_full;
  logic                  emit;
  logic [EVENT_W-1:0]    res_event;
  logic [WHO_W-1:0]      res_who;
  logic                  res_last;

  // slot and index arithmetic
  always_comb begin
    if (cur.new_limit < NEW_LIMIT_W'(MIN_LIMIT)) begin
      lim_clamped = SLOT_W'(MIN_LIMIT);
    end else if (cur.new_limit > NEW_LIMIT_W'(MAX_LIMIT)) begin
      lim_clamped = SLOT_W'(MAX_LIMIT);
    end else begin
      lim_clamped = SLOT_W'(cur.new_limit);
    end
    act_dec    = (active_slots != '0) ? active_slots - SLOT_W'(1) : active_slots;
    act_inc    = SLOT_INC_W'(active_slots) + SLOT_INC_W'(1);
    idx_inc    = idx + CNT_W'(1);
    idx_inc2   = idx + CNT_W'(2);
    can_grant  = (active_slots < slot_limit);
    queue_full = (wait_count >= CNT_W'(QUEUE_DEPTH));
  end

  // status toward the controller
  always_comb begin
    stat.is_acquire  = (cur.kind == KIND_ACQUIRE);
    stat.is_release  = (cur.kind == KIND_RELEASE);
    stat.is_cancel   = (cur.kind == KIND_CANCEL);
    stat.is_setlim   = (cur.kind == KIND_SETLIM);
    stat.is_flush    = (cur.kind == KIND_FLUSH);
    stat.queue_empty = (wait_count == '0);
    stat.rel_last    = (wait_count == '0) || !(act_dec < slot_limit);
    stat.set_last    = (wait_count == '0) || !(active_slots < lim_clamped);
    stat.promo_last  = (wait_count == CNT_W'(1)) || !(act_inc < SLOT_INC_W'(slot_limit));
    stat.flush_last  = (wait_count == CNT_W'(1));
    stat.match       = (rd_data == ID_W'(cur.requester));
    stat.scan_end    = (idx_inc == wait_count);
    stat.shift_end   = (idx_inc2 >= wait_count);
    stat.out_free    = !ev_valid || ev_ready;
  end

  // queue read address
  always_comb begin
    unique case (cmd.rd_sel)
      RD_HEAD:      rd_addr = head;
      RD_SCAN:      rd_addr = ptr_add(head, idx[PTR_W-1:0]);
      RD_SCAN_NEXT: rd_addr = ptr_add(head, idx_inc[PTR_W-1:0]);
      default:      rd_addr = head;
    endcase
  end

  // micro-operation decode
  always_comb begin
    slot_limit_next   = slot_limit;
    active_slots_next = active_slots;
    wait_count_next   = wait_count;
    head_next         = head;
    idx_next          = idx;
    found_next        = found;
    cur_next          = cur;
    emit              = 1'b0;
    res_event         = EV_GRANTED;
    res_who           = '0;
    res_last          = 1'b0;
    mem_we            = 1'b0;
    wr_addr           = ptr_add(head, wait_count[PTR_W-1:0]);
    wr_data           = ID_W'(cur.requester);
    unique case (cmd.uop)
      UOP_NONE: begin
      end
      UOP_LATCH: begin
        cur_next   = op;
        found_next = 1'b0;
      end
      UOP_ACQUIRE: begin
        emit     = 1'b1;
        res_who  = WHO_W'(cur.requester);
        res_last = 1'b1;
        if (can_grant) begin
          active_slots_next = active_slots + SLOT_W'(1);
          res_event         = EV_GRANTED;
        end else if (!cur.may_wait || queue_full) begin
          res_event = EV_REFUSED;
        end else begin
          mem_we          = 1'b1;
          wait_count_next = wait_count + CNT_W'(1);
          res_event       = EV_QUEUED;
        end
      end
      UOP_RELEASE: begin
        emit              = 1'b1;
        active_slots_next = act_dec;
        res_event         = EV_RELEASED;
        res_last          = stat.rel_last;
      end
      UOP_SETLIM: begin
        emit            = 1'b1;
        slot_limit_next = lim_clamped;
        res_event       = EV_LIMIT_SET;
        res_last        = stat.set_last;
      end
      UOP_PROMOTE: begin
        emit              = 1'b1;
        active_slots_next = act_inc[SLOT_W-1:0];
        wait_count_next   = wait_count - CNT_W'(1);
        head_next         = ptr_add(head, PTR_W'(1));
        res_event         = EV_PROMOTED;
        res_who           = WHO_W'(rd_data);
        res_last          = stat.promo_last;
      end
      UOP_FLUSH_ONE: begin
        emit            = 1'b1;
        wait_count_next = wait_count - CNT_W'(1);
        head_next       = ptr_add(head, PTR_W'(1));
        res_event       = EV_FLUSHED;
        res_who         = WHO_W'(rd_data);
      end
      UOP_FLUSH_DONE: begin
        emit      = 1'b1;
        res_event = EV_FLUSH_DONE;
        res_last  = 1'b1;
      end
      UOP_SCAN_START: begin
        idx_next = '0;
      end
      UOP_SCAN_STEP: begin
        if (stat.match) begin
          found_next = 1'b1;
        end else begin
          idx_next = idx_inc;
        end
      end
      UOP_SHIFT_WR: begin
        // move the entry behind the gap one place toward the head
        mem_we   = 1'b1;
        wr_addr  = ptr_add(head, idx[PTR_W-1:0]);
        wr_data  = rd_data;
        idx_next = idx_inc;
      end
      UOP_CANCEL_END: begin
        emit     = 1'b1;
        res_who  = WHO_W'(cur.requester);
        res_last = 1'b1;
        if (found) begin
          wait_count_next = wait_count - CNT_W'(1);
          res_event       = EV_CANCELLED;
        end else begin
          res_event = EV_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
    ev_next.event_res    = res_event;
    ev_next.who          = res_who;
    ev_next.active_count = ACT_OUT_W'(active_slots_next);
    ev_next.queued_count = Q_OUT_W'(wait_count_next);
    ev_next.last         = res_last;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit   <= SLOT_W'(MIN_LIMIT);
      active_slots <= '0;
      wait_count   <= '0;
      head         <= '0;
      idx          <= '0;
      found        <= 1'b0;
      ev_valid     <= 1'b0;
    end else begin
      slot_limit   <= slot_limit_next;
      active_slots <= active_slots_next;
      wait_count   <= wait_count_next;
      head         <= head_next;
      idx          <= idx_next;
      found        <= found_next;
      if (emit) begin
        ev_valid <= 1'b1;
      end else if (ev_ready) begin
        ev_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (emit) begin
      ev <= ev_next;
    end
  end

  // wait queue storage, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      wait_queue[wr_addr] <= wr_data;
    end
    rd_data <= wait_queue[rd_addr];
  end

endmodule

// ===== rtl/core/slot_admission_gate_core.sv =====
// slot admission gate: counting gate with a bounded wait queue
// op channel (op_valid/op_ready/op) carries one request item: acquire,
// release, cancel, set limit or flush. ev channel (ev_valid/ev_ready/ev)
// returns the event items it causes; the final one has last set.
// one request item is worked on at a time; op_ready is high only when the
// gate is idle, and the next item can enter while the last event still
// sits in the output register.
// acquire, release, set limit and any item on an empty queue load the
// event register from the dispatch state; each promotion and each flushed
// waiter first reads the queue head, then emits its event.
// acquire and cancel give one event, release and set limit give 1 + k
// events for k promotions, flush gives n + 1 events for n waiters.
// the wait queue has one read and one write port, and its reads are
// registered; cancel scans it one entry at a time and then closes the gap.
// reset: slot limit goes to its minimum, no slots held, queue empty.
// a stall on ev_ready holds the event register and freezes the sequencer
// at the next event; nothing is dropped.
module slot_admission_gate_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         op_valid,
  output logic         op_ready,
  input  sag_pkg::op_t op,
  output logic         ev_valid,
  input  logic         ev_ready,
  output sag_pkg::ev_t ev
);
  import sag_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  sag_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // counters, wait queue and event register
  sag_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .cmd      (cmd),
    .stat     (stat),
    .ev_valid (ev_valid),
    .ev_ready (ev_ready),
    .ev       (ev)
  );

endmodule

// ===== rtl/core/sag_checker.sv =====
`include "slot_admission_gate_core_assert.svh"

module sag_checker (
  input logic         clk,
  input logic         rst,
  input logic         op_valid,
  input logic         op_ready,
  input logic         ev_valid,
  input logic         ev_ready,
  input sag_pkg::ev_t ev
);
  import sag_pkg::*;

  logic flush_done_ev;

  // a flush done event on the output
  assign flush_done_ev = ev_valid && (ev.event_res == EV_FLUSH_DONE);

  // an accepted item always takes the gate out of idle
  `SAG_ASSERT_NEXT(a_busy_after_accept, clk, rst, op_valid && op_ready, !op_ready)

  // no new item while an unfinished event sequence is pending
  `SAG_ASSERT_IMPL(a_no_accept_mid_seq, clk, rst, ev_valid && !ev.last, !op_ready)

  // flush done closes the sequence with an empty queue
  `SAG_ASSERT_IMPL(a_flush_done_empty, clk, rst, flush_done_ev, ev.queued_count == '0 && ev.last)

  // a stalled event holds
  `SAG_ASSERT_NEXT(a_ev_hold, clk, rst, ev_valid && !ev_ready, ev_valid && $stable(ev))

endmodule

bind slot_admission_gate_core sag_checker u_sag_checker (
  .clk      (clk),
  .rst      (rst),
  .op_valid (op_valid),
  .op_ready (op_ready),
  .ev_valid (ev_valid),
  .ev_ready (ev_ready),
  .ev       (ev)
);
